### design/fatc_pkg.sv
// Shared constants and types for the first-arrival timestamp capture core.
package fatc_pkg;

    localparam int CHANNELS_DEF   = 4;
    localparam int COUNT_BITS_DEF = 32;
    localparam int QUEUE_DEPTH    = 2;
    localparam int EDGE_BITS      = 4;
    localparam int MAX_CHANNELS   = 8;
    localparam int CFG_BITS       = 32;

    localparam logic [CFG_BITS-1:0] TIMEOUT_RESET = CFG_BITS'(84000000 / 2);
    localparam logic [7:0]          ID_BASE       = 8'h41;

    localparam logic REQ_TICK = 1'b0;
    localparam logic REQ_ARM  = 1'b1;

    localparam logic STATUS_PACKET  = 1'b0;
    localparam logic STATUS_TIMEOUT = 1'b1;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_stat_t;

endpackage

### design/fatc_if.sv
// Valid/ready channel interfaces for requests and result bytes.
interface fatc_req_if;
    logic       valid;
    logic       ready;
    logic       req_type;
    logic [3:0] edges;

    modport source (output valid, output req_type, output edges, input ready);
    modport sink   (input valid, input req_type, input edges, output ready);
endinterface

interface fatc_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last;
    logic       status;

    modport source (output valid, output data_byte, output last, output status, input ready);
    modport sink   (input valid, input data_byte, input last, input status, output ready);
endinterface

### design/first_arrival_timestamp_capture_core.sv
// Top level of the first-arrival timestamp capture core.
//
//  port      dir   beat contents
//  --------  ----  ------------------------------------------------
//  request   in    req_type (tick / arm), edges per channel
//  result    out   data_byte, last, status (packet byte / timeout)
//  cfg_we    in    write strobe for timeout_ticks (cfg_wdata)
//
// One request beat per cycle; request.ready drops only while the two-entry
// record queue is full, which needs two finished captures waiting behind
// the serializer. A packet leaves as CHANNELS * (1 + stamp bytes) result beats,
// one per ready cycle, from the serializer registers; a timeout is one beat.
// Asynchronous active-low reset clears control state and loads the default
// timeout; no clearing pass, stamps are written before any packet reads them.
module first_arrival_timestamp_capture_core #(
    parameter int CHANNELS    = fatc_pkg::CHANNELS_DEF,
    parameter int COUNT_BITS  = fatc_pkg::COUNT_BITS_DEF,
    parameter int QUEUE_DEPTH = fatc_pkg::QUEUE_DEPTH
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [fatc_pkg::CFG_BITS-1:0] cfg_wdata,
    fatc_req_if.sink                      request,
    fatc_byte_if.source                   result
);

    localparam int ENTRY_W = CHANNELS * COUNT_BITS + 1;

    fatc_pkg::queue_stat_t qstat;
    logic                  push, pop;
    logic [ENTRY_W-1:0]    push_data, head;

    fatc_front #(
        .CHANNELS   (CHANNELS),
        .COUNT_BITS (COUNT_BITS),
        .ENTRY_W    (ENTRY_W)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .request   (request),
        .qstat     (qstat),
        .push      (push),
        .push_data (push_data)
    );

    fatc_queue #(
        .ENTRY_W (ENTRY_W),
        .DEPTH   (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .head      (head),
        .qstat     (qstat)
    );

    fatc_back #(
        .CHANNELS   (CHANNELS),
        .COUNT_BITS (COUNT_BITS),
        .ENTRY_W    (ENTRY_W)
    ) u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .head   (head),
        .qstat  (qstat),
        .pop    (pop),
        .result (result)
    );

endmodule

### design/fatc_front.sv
// Capture engine: accepts arm and tick beats, latches first-edge stamps, pushes records.
module fatc_front #(
    parameter int CHANNELS   = fatc_pkg::CHANNELS_DEF,
    parameter int COUNT_BITS = fatc_pkg::COUNT_BITS_DEF,
    parameter int ENTRY_W    = CHANNELS * COUNT_BITS + 1
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [fatc_pkg::CFG_BITS-1:0]  cfg_wdata,
    fatc_req_if.sink                       request,
    input  fatc_pkg::queue_stat_t          qstat,
    output logic                           push,
    output logic [ENTRY_W-1:0]             push_data
);

    localparam int CMP_W = (COUNT_BITS > fatc_pkg::CFG_BITS) ? COUNT_BITS : fatc_pkg::CFG_BITS;

    logic [fatc_pkg::CFG_BITS-1:0]      timeout_reg;
    logic                               running_reg, running_next;
    logic [CHANNELS-1:0]                mask_reg, mask_next;
    logic [COUNT_BITS-1:0]              count_reg, count_next;
    logic [CHANNELS-1:0][COUNT_BITS-1:0] stamps_reg, stamps_next;

    logic [fatc_pkg::MAX_CHANNELS-1:0]  edges_wide;
    logic [CHANNELS-1:0]                take;
    logic [COUNT_BITS-1:0]              count_inc;
    logic                               fire, tick, done, timed_out;

    assign request.ready = !qstat.full;
    assign fire          = request.valid && request.ready;
    assign tick          = fire && (request.req_type == fatc_pkg::REQ_TICK) && running_reg;

    // channels beyond the edge field never see an edge
    assign edges_wide = {{(fatc_pkg::MAX_CHANNELS - fatc_pkg::EDGE_BITS){1'b0}}, request.edges};
    assign take       = edges_wide[CHANNELS-1:0] & ~mask_reg;
    assign count_inc  = count_reg + 1'b1;
    assign done       = &(mask_reg | take);
    assign timed_out  = !done && (CMP_W'(count_inc) == CMP_W'(timeout_reg));

    always_comb
    begin
        running_next = running_reg;
        mask_next    = mask_reg;
        count_next   = count_reg;
        stamps_next  = stamps_reg;
        if (fire && (request.req_type == fatc_pkg::REQ_ARM))
        begin
            running_next = 1'b1;
            mask_next    = '0;
            count_next   = '0;
        end
        else if (tick)
        begin
            for (int ch = 0; ch < CHANNELS; ch++)
            begin
                if (take[ch])
                begin
                    stamps_next[ch] = count_reg;
                end
            end
            mask_next  = mask_reg | take;
            count_next = count_inc;
            if (done || timed_out)
            begin
                running_next = 1'b0;
            end
        end
    end

    assign push      = tick && (done || timed_out);
    assign push_data = {timed_out, stamps_next};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg <= fatc_pkg::TIMEOUT_RESET;
            running_reg <= 1'b0;
            mask_reg    <= '0;
            count_reg   <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                timeout_reg <= cfg_wdata;
            end
            running_reg <= running_next;
            mask_reg    <= mask_next;
            count_reg   <= count_next;
        end
    end

    // payload only: stamps are always rewritten before a packet reads them
    always_ff @(posedge clk)
    begin
        stamps_reg <= stamps_next;
    end

    a_push_not_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !qstat.full)
        else $error("record pushed into a full queue");

    a_stop_after_push: assert property (@(posedge clk) disable iff (!rst_n)
        push |=> !running_reg)
        else $error("capture still running after its record was pushed");

    a_idle_no_count: assert property (@(posedge clk) disable iff (!rst_n)
        (!running_reg && !(fire && request.req_type == fatc_pkg::REQ_ARM)) |=> $stable(count_reg))
        else $error("tick counter moved while idle");

endmodule

### design/fatc_queue.sv
// Short record queue between the capture engine and the serializer.
module fatc_queue #(
    parameter int ENTRY_W = 129,
    parameter int DEPTH   = fatc_pkg::QUEUE_DEPTH
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  logic [ENTRY_W-1:0]    push_data,
    input  logic                  pop,
    output logic [ENTRY_W-1:0]    head,
    output fatc_pkg::queue_stat_t qstat
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [ENTRY_W-1:0] mem [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;

    function automatic logic [PTR_W-1:0] ptr_adv(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign qstat.full  = (count_reg == CNT_W'(DEPTH));
    assign qstat.empty = (count_reg == '0);
    assign head        = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ptr_adv(wr_ptr_reg);
            end
            if (pop)
            begin
                rd_ptr_reg <= ptr_adv(rd_ptr_reg);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue occupancy beyond depth");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !qstat.empty)
        else $error("pop from an empty queue");

endmodule

### design/fatc_back.sv
// Serializer: turns queued records into packet bytes or a timeout beat.
module fatc_back #(
    parameter int CHANNELS   = fatc_pkg::CHANNELS_DEF,
    parameter int COUNT_BITS = fatc_pkg::COUNT_BITS_DEF,
    parameter int ENTRY_W    = CHANNELS * COUNT_BITS + 1
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [ENTRY_W-1:0]    head,
    input  fatc_pkg::queue_stat_t qstat,
    output logic                  pop,
    fatc_byte_if.source           result
);

    localparam int SB     = (COUNT_BITS + 7) / 8;
    localparam int POS_W  = $clog2(SB + 1);
    localparam int BYTE_W = (SB > 1) ? $clog2(SB) : 1;
    localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    logic                    busy_reg;
    logic [ENTRY_W-1:0]      rec_reg;
    logic [CH_W-1:0]         ch_reg;
    logic [POS_W-1:0]        pos_reg;

    logic [CHANNELS-1:0][COUNT_BITS-1:0] stamps;
    logic [SB-1:0][7:0]      stamp_bytes;
    logic [POS_W-1:0]        byte_sel;
    logic                    tmo, beat, is_last, load, pos_end;

    assign tmo         = rec_reg[ENTRY_W-1];
    assign stamps      = rec_reg[CHANNELS*COUNT_BITS-1:0];
    assign stamp_bytes = (SB*8)'(stamps[ch_reg]);
    assign byte_sel    = POS_W'(SB) - pos_reg;
    assign pos_end     = (pos_reg == POS_W'(SB));

    assign is_last = tmo || (pos_end && (ch_reg == CH_W'(CHANNELS - 1)));
    assign beat    = result.valid && result.ready;
    assign load    = !busy_reg || (beat && is_last);
    assign pop     = load && !qstat.empty;

    always_comb
    begin
        if (tmo)
        begin
            result.data_byte = 8'h00;
        end
        else if (pos_reg == '0)
        begin
            result.data_byte = fatc_pkg::ID_BASE + 8'(ch_reg);
        end
        else
        begin
            result.data_byte = stamp_bytes[byte_sel[BYTE_W-1:0]];
        end
    end

    assign result.valid  = busy_reg;
    assign result.last   = is_last;
    assign result.status = tmo ? fatc_pkg::STATUS_TIMEOUT : fatc_pkg::STATUS_PACKET;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            ch_reg   <= '0;
            pos_reg  <= '0;
        end
        else if (load)
        begin
            busy_reg <= !qstat.empty;
            ch_reg   <= '0;
            pos_reg  <= '0;
        end
        else if (beat)
        begin
            // advance to the next channel after its last stamp byte
            if (pos_end)
            begin
                pos_reg <= '0;
                ch_reg  <= ch_reg + 1'b1;
            end
            else
            begin
                pos_reg <= pos_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            rec_reg <= head;
        end
    end

    a_drain_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (beat && is_last && qstat.empty) |=> !result.valid)
        else $error("serializer still busy after its last beat with nothing queued");

    a_timeout_single: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.status == fatc_pkg::STATUS_TIMEOUT) |-> result.last)
        else $error("timeout result not marked last");

endmodule

### dv/tb.sv
// Testbench for the first-arrival timestamp capture core: queued stimulus, predicted bytes.
`timescale 1ns / 100ps

module tb;

    localparam int          NUM_CH        = fatc_pkg::CHANNELS_DEF;
    localparam int          STAMP_BYTES   = (fatc_pkg::COUNT_BITS_DEF + 7) / 8;
    localparam logic [3:0]  CHAN_ALL      = 4'((1 << NUM_CH) - 1);
    localparam logic [31:0] TIMEOUT_BOOT  = 32'd42_000_000;
    localparam int          SETTLE_CYCLES = 16;
    localparam int          CYCLE_LIMIT   = 200_000;

    typedef struct packed {
        logic       req_type;
        logic [3:0] edges;
    } capture_req_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last;
        logic       status;
    } result_beat_t;

    logic                          clk;
    logic                          rst_n;
    logic                          cfg_we;
    logic [fatc_pkg::CFG_BITS-1:0] cfg_wdata;

    fatc_req_if  req_if ();
    fatc_byte_if res_if ();

    first_arrival_timestamp_capture_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .request   (req_if),
        .result    (res_if)
    );

    capture_req_t request_backlog[$];
    result_beat_t pending_bytes[$];
    capture_req_t drive_req;
    capture_req_t seen_req;
    result_beat_t want_beat;

    // Predicted capture state
    logic        cap_running = 1'b0;
    logic [3:0]  cap_mask    = '0;
    logic [31:0] cap_count   = '0;
    logic [31:0] cap_timeout = TIMEOUT_BOOT;
    logic [31:0] cap_stamps [NUM_CH];

    int send_idle_pct  = 37;
    int recv_stall_pct = 57;
    int failures       = 0;
    int cycle_count    = 0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic push_result(input logic [7:0] data_byte, input logic last,
                               input logic status);
        result_beat_t beat;
        beat.data_byte = data_byte;
        beat.last      = last;
        beat.status    = status;
        pending_bytes.push_back(beat);
    endtask

    // Advance the capture state by one accepted request and queue its bytes.
    task automatic predict_capture_bytes(input capture_req_t rq);
        logic [3:0] hits;
        int         ch;
        int         bi;
        if (rq.req_type == fatc_pkg::REQ_ARM)
        begin
            cap_mask    = '0;
            cap_count   = '0;
            cap_running = 1'b1;
        end
        else if (cap_running)
        begin
            hits = rq.edges & CHAN_ALL & ~cap_mask;
            for (ch = 0; ch < NUM_CH; ch++)
            begin
                if (hits[ch])
                    cap_stamps[ch] = cap_count;
            end
            cap_mask  = cap_mask | hits;
            cap_count = cap_count + 32'd1;
            // completion wins over a timeout on the same tick
            if (cap_mask == CHAN_ALL)
            begin
                cap_running = 1'b0;
                for (ch = 0; ch < NUM_CH; ch++)
                begin
                    push_result(fatc_pkg::ID_BASE + 8'(ch), 1'b0, fatc_pkg::STATUS_PACKET);
                    for (bi = STAMP_BYTES - 1; bi >= 0; bi--)
                        push_result(cap_stamps[ch][8*bi +: 8],
                                    (ch == NUM_CH - 1) && (bi == 0),
                                    fatc_pkg::STATUS_PACKET);
                end
            end
            else if (cap_count == cap_timeout)
            begin
                cap_running = 1'b0;
                push_result(8'h00, 1'b1, fatc_pkg::STATUS_TIMEOUT);
            end
        end
    endtask

    task automatic queue_request(input logic req_type, input logic [3:0] edges);
        capture_req_t rq;
        rq.req_type = req_type;
        rq.edges    = edges;
        request_backlog.push_back(rq);
    endtask

    // Hold until every queued request is taken and every predicted byte is out.
    task automatic wait_drained();
        do
            @(negedge clk);
        while (request_backlog.size() != 0 || req_if.valid || pending_bytes.size() != 0);
    endtask

    // Finish any open capture, let the core settle, then load timeout_ticks.
    task automatic write_timeout(input logic [31:0] ticks);
        wait_drained();
        if (cap_running)
        begin
            queue_request(fatc_pkg::REQ_TICK, CHAN_ALL);
            wait_drained();
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= ticks;
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(negedge clk);
    endtask

    // One arm followed by ticks until every channel has shown an edge or the run is
    // cut short; now and then only stray ticks with no arm in front.
    task automatic queue_capture_run(output int well_formed);
        int         pct;
        int         run_limit;
        int         n;
        int         ch;
        logic [3:0] seen;
        logic [3:0] e;
        well_formed = 0;
        if ($urandom_range(9) == 0)
        begin
            n = $urandom_range(1, 3);
            repeat (n) queue_request(fatc_pkg::REQ_TICK, 4'($urandom_range(15)));
        end
        else
        begin
            pct       = $urandom_range(10, 60);
            run_limit = $urandom_range(2, 30);
            seen      = '0;
            queue_request(fatc_pkg::REQ_ARM, 4'($urandom_range(15)));
            well_formed = 1;
            while (seen != CHAN_ALL && well_formed <= run_limit)
            begin
                e = '0;
                for (ch = 0; ch < NUM_CH; ch++)
                begin
                    if ($urandom_range(99) < pct)
                        e[ch] = 1'b1;
                end
                queue_request(fatc_pkg::REQ_TICK, e);
                seen = seen | e;
                well_formed++;
            end
        end
    endtask

    // Request driver
    always @(posedge clk)
    begin
        if (!rst_n)
            req_if.valid <= 1'b0;
        else if (!req_if.valid || req_if.ready)
        begin
            if (request_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                drive_req = request_backlog.pop_front();
                req_if.valid    <= 1'b1;
                req_if.req_type <= drive_req.req_type;
                req_if.edges    <= drive_req.edges;
            end
            else
            begin
                req_if.valid    <= 1'b0;
                req_if.req_type <= 1'($urandom_range(1));
                req_if.edges    <= 4'($urandom_range(15));
            end
        end
    end

    // Result receiver
    always @(posedge clk)
    begin
        if (!rst_n)
            res_if.ready <= 1'b0;
        else
            res_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Monitor: check result beats first, then predict from the accepted request.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            cap_running = 1'b0;
            cap_mask    = '0;
            cap_count   = '0;
            cap_timeout = TIMEOUT_BOOT;
        end
        else
        begin
            if (res_if.valid && res_if.ready)
            begin
                if (pending_bytes.size() == 0)
                begin
                    $error("unexpected result beat: data_byte %0h last %0b status %0b",
                           res_if.data_byte, res_if.last, res_if.status);
                    failures++;
                end
                else
                begin
                    want_beat = pending_bytes.pop_front();
                    if (res_if.data_byte !== want_beat.data_byte)
                    begin
                        $error("data_byte: expected %0h, got %0h",
                               want_beat.data_byte, res_if.data_byte);
                        failures++;
                    end
                    if (res_if.last !== want_beat.last)
                    begin
                        $error("last: expected %0b, got %0b", want_beat.last, res_if.last);
                        failures++;
                    end
                    if (res_if.status !== want_beat.status)
                    begin
                        $error("status: expected %0b, got %0b",
                               want_beat.status, res_if.status);
                        failures++;
                    end
                end
            end
            if (cfg_we)
                cap_timeout = cfg_wdata;
            if (req_if.valid && req_if.ready)
            begin
                seen_req.req_type = req_if.req_type;
                seen_req.edges    = req_if.edges;
                predict_capture_bytes(seen_req);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("first_arrival_timestamp_capture_core: mismatch");
            $finish;
        end
    end

    initial
    begin
        int          phase;
        int          phase_items;
        int          run_items;
        logic [31:0] next_timeout;

        rst_n           = 1'b0;
        cfg_we          = 1'b0;
        cfg_wdata       = '0;
        req_if.valid    = 1'b0;
        req_if.req_type = fatc_pkg::REQ_TICK;
        req_if.edges    = '0;
        res_if.ready    = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Boot timeout: idle tick, arm with edges, repeat edges, restart while running
        queue_request(fatc_pkg::REQ_TICK, 4'hF);
        queue_request(fatc_pkg::REQ_ARM,  4'hF);
        queue_request(fatc_pkg::REQ_TICK, 4'h0);
        queue_request(fatc_pkg::REQ_TICK, 4'h1);
        queue_request(fatc_pkg::REQ_TICK, 4'h1);
        queue_request(fatc_pkg::REQ_TICK, 4'h6);
        queue_request(fatc_pkg::REQ_ARM,  4'h0);
        queue_request(fatc_pkg::REQ_TICK, 4'hF);
        queue_request(fatc_pkg::REQ_TICK, 4'hF);

        // Shortest timeout: expire on the first tick, or complete on it
        write_timeout(32'd1);
        queue_request(fatc_pkg::REQ_ARM,  4'h0);
        queue_request(fatc_pkg::REQ_TICK, 4'h0);
        queue_request(fatc_pkg::REQ_TICK, 4'h0);
        queue_request(fatc_pkg::REQ_ARM,  4'h5);
        queue_request(fatc_pkg::REQ_TICK, 4'hF);

        // Third channel on the timeout tick versus the last channel on it
        write_timeout(32'd3);
        queue_request(fatc_pkg::REQ_ARM,  4'h0);
        queue_request(fatc_pkg::REQ_TICK, 4'h1);
        queue_request(fatc_pkg::REQ_TICK, 4'h2);
        queue_request(fatc_pkg::REQ_TICK, 4'h4);
        queue_request(fatc_pkg::REQ_TICK, 4'h8);
        queue_request(fatc_pkg::REQ_ARM,  4'hA);
        queue_request(fatc_pkg::REQ_TICK, 4'h1);
        queue_request(fatc_pkg::REQ_TICK, 4'h2);
        queue_request(fatc_pkg::REQ_TICK, 4'hC);

        // Longest timeout: channels arrive in reverse order
        write_timeout(32'hFFFF_FFFF);
        queue_request(fatc_pkg::REQ_ARM,  4'h0);
        queue_request(fatc_pkg::REQ_TICK, 4'h8);
        queue_request(fatc_pkg::REQ_TICK, 4'h4);
        queue_request(fatc_pkg::REQ_TICK, 4'h2);
        queue_request(fatc_pkg::REQ_TICK, 4'h1);

        for (phase = 0; phase < 3; phase++)
        begin
            send_idle_pct  = (phase == 0) ? 37 : (phase == 1) ? 57 : 0;
            recv_stall_pct = (phase == 0) ? 57 : (phase == 1) ? 37 : 0;
            phase_items    = 0;
            while (phase_items < 22)
            begin
                if ($urandom_range(3) == 0)
                begin
                    case ($urandom_range(5))
                        0:       next_timeout = 32'd1;
                        1:       next_timeout = 32'hFFFF_FFFF;
                        2:       next_timeout = $urandom_range(2, 8);
                        3:       next_timeout = $urandom;
                        default: next_timeout = $urandom_range(9, 40);
                    endcase
                    write_timeout(next_timeout);
                end
                queue_capture_run(run_items);
                phase_items += run_items;
                if ($urandom_range(5) == 0)
                    wait_drained();
                while (request_backlog.size() > 4)
                    @(negedge clk);
            end
        end

        wait_drained();
        repeat (32) @(posedge clk);
        if (failures == 0)
        begin
            $display("first_arrival_timestamp_capture_core: match");
        end
        else
        begin
            $display("first_arrival_timestamp_capture_core: mismatch");
        end
        $finish;
    end

endmodule
